>>> rtl/nge_pkg.sv
// ----------------------------------------------------------------------------
// nge_pkg
// shared types and codes of the gate netlist evaluator
// ----------------------------------------------------------------------------
`default_nettype none

package nge_pkg;

  // node index width on the ports, and the number of indices it can name
  localparam int NODE_W         = 6;
  localparam int NODE_IDX_RANGE = 1 << NODE_W;
  localparam int KIND_W         = 3;

  typedef enum logic [2:0] {
    OP_ADD  = 3'd0,
    OP_SET  = 3'd1,
    OP_SIM  = 3'd2,
    OP_READ = 3'd3,
    OP_ALL  = 3'd4
  } opcode_t;

  // gate kinds
  localparam logic [KIND_W-1:0] GT_AND  = 3'd0;
  localparam logic [KIND_W-1:0] GT_OR   = 3'd1;
  localparam logic [KIND_W-1:0] GT_NAND = 3'd2;
  localparam logic [KIND_W-1:0] GT_NOR  = 3'd3;
  localparam logic [KIND_W-1:0] GT_XOR  = 3'd4;
  localparam logic [KIND_W-1:0] GT_XNOR = 3'd5;
  localparam logic [KIND_W-1:0] GT_NOT  = 3'd6;

  // result status codes
  localparam logic [1:0] STS_OK     = 2'd0;
  localparam logic [1:0] STS_FULL   = 2'd1;
  localparam logic [1:0] STS_UNUSED = 2'd2;
  localparam logic [1:0] STS_BAD    = 2'd3;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_SIM_GATE,
    S_SIM_FETCH,
    S_SIM_EVAL,
    S_SIM_DONE,
    S_SCAN,
    S_SCAN_OUT
  } state_t;

  // one gate table entry, 21 bits
  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [NODE_W-1:0] a;
    logic [NODE_W-1:0] b;
    logic [NODE_W-1:0] d;
  } gate_entry_t;

  // sequencer to node value memory
  typedef struct packed {
    logic              rd_en;
    logic [NODE_W-1:0] rd_a;
    logic [NODE_W-1:0] rd_b;
    logic              wr_en;
    logic [NODE_W-1:0] wr_addr;
    logic              wr_data;
  } node_port_t;

endpackage

`default_nettype wire

>>> rtl/nge_gate_alu.sv
// ----------------------------------------------------------------------------
// nge_gate_alu
// shared two-input logic unit, one gate evaluated per use
// ----------------------------------------------------------------------------
`default_nettype none

module nge_gate_alu (
  input  wire logic [nge_pkg::KIND_W-1:0] kind,
  input  wire logic                       a,
  input  wire logic                       b,
  output logic                            y
);
  import nge_pkg::*;

  always_comb begin
    case (kind)
      GT_AND:  y = a & b;
      GT_OR:   y = a | b;
      GT_NAND: y = ~(a & b);
      GT_NOR:  y = ~(a | b);
      GT_XOR:  y = a ^ b;
      GT_XNOR: y = ~(a ^ b);
      default: y = ~a;
    endcase
  end

endmodule

`default_nettype wire

>>> rtl/nge_gate_mem.sv
// ----------------------------------------------------------------------------
// nge_gate_mem
// gate table, one write and one registered read port
// ----------------------------------------------------------------------------
`default_nettype none

module nge_gate_mem #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  wire logic                  clk,
  input  wire logic                  wr_en,
  input  wire logic [AW-1:0]         wr_addr,
  input  wire nge_pkg::gate_entry_t  wr_data,
  input  wire logic                  rd_en,
  input  wire logic [AW-1:0]         rd_addr,
  output nge_pkg::gate_entry_t       rd_data
);
  import nge_pkg::*;

  gate_entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

>>> rtl/nge_node_mem.sv
// ----------------------------------------------------------------------------
// nge_node_mem
// node value store, two registered reads and one write
// ----------------------------------------------------------------------------
`default_nettype none

module nge_node_mem #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire nge_pkg::node_port_t port,
  output logic                     rd_data_a,
  output logic                     rd_data_b
);
  import nge_pkg::*;

  logic             mem [DEPTH];
  // written flags, an entry never written reads as zero
  logic [DEPTH-1:0] written;

  always_ff @(posedge clk) begin
    if (port.wr_en) begin
      mem[port.wr_addr[AW-1:0]] <= port.wr_data;
    end
    if (port.rd_en) begin
      rd_data_a <= written[port.rd_a[AW-1:0]] & mem[port.rd_a[AW-1:0]];
      rd_data_b <= written[port.rd_b[AW-1:0]] & mem[port.rd_b[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      written <= '0;
    end else if (port.wr_en) begin
      written[port.wr_addr[AW-1:0]] <= 1'b1;
    end
  end

endmodule

`default_nettype wire

>>> rtl/netlist_gate_evaluator_core.sv
// ----------------------------------------------------------------------------
// netlist_gate_evaluator_core
// command driven evaluator of a two-input gate netlist
// ----------------------------------------------------------------------------
// usage:
//   commands arrive on the s_ channel, one transaction each; results leave on
//   the m_ channel, the final result of a command marked by m_tlast.
//   add gate, set node, bad opcode and failed checks answer in the accept
//   cycle, the result visible in the cycle after.
//   read node does a registered read of the node value memory, then S_READ
//   loads the result. simulate walks every gate in the table through
//   S_SIM_GATE, S_SIM_FETCH and S_SIM_EVAL: the sequencer fetches the gate
//   entry, reads both input values, then the shared logic unit evaluates
//   and writes the output node. read all walks the node-used flags one index
//   per cycle up to the highest used node, but waits in S_SCAN_OUT for a
//   free output register at every used node reported.
//   s_tready is high only while the sequencer is idle and the output
//   register is free or being emptied, so one command is in work at a time.
//   a stalled receiver holds the result in the output register and stops
//   the sequencer where it waits to emit.
//   reset clears the gate count, the node-used flags and the node values
//   (through the written flags); gate table contents stay unknown and are
//   never read beyond the gate count.
// ----------------------------------------------------------------------------
`default_nettype none

module netlist_gate_evaluator_core #(
  parameter int MAX_GATES = 64,
  parameter int MAX_NODES = 64
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // command channel
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [23:0] s_tdata,   // node_a[5:0], node_b[11:6], node_out[17:12],
                                      // set_value[18], zero pad[23:19]
  input  wire logic [5:0]  s_tuser,   // opcode[2:0], gate_type[5:3]
  // result channel
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [7:0]       m_tdata,   // node_index[5:0], node_value[6], zero pad[7]
  output logic [1:0]       m_tuser,   // status[1:0]
  output logic             m_tlast
);
  import nge_pkg::*;

  // only indices the 6-bit fields can name are ever stored
  localparam int NODE_DEPTH = (MAX_NODES < NODE_IDX_RANGE) ? MAX_NODES : NODE_IDX_RANGE;
  localparam int NODE_AW    = $clog2(NODE_DEPTH);
  localparam int GATE_AW    = $clog2(MAX_GATES);
  localparam int CNT_W      = $clog2(MAX_GATES + 1);

  // command fields
  opcode_t            cmd_op;
  logic [KIND_W-1:0]  cmd_kind;
  logic [NODE_W-1:0]  cmd_a;
  logic [NODE_W-1:0]  cmd_b;
  logic [NODE_W-1:0]  cmd_d;
  logic               cmd_sv;
  logic               s_accept;

  assign cmd_op   = opcode_t'(s_tuser[2:0]);
  assign cmd_kind = s_tuser[5:3];
  assign cmd_a    = s_tdata[5:0];
  assign cmd_b    = s_tdata[11:6];
  assign cmd_d    = s_tdata[17:12];
  assign cmd_sv   = s_tdata[18];

  // state
  state_t               state;
  state_t               state_next;
  logic [CNT_W-1:0]     gate_count;
  logic [CNT_W-1:0]     gate_idx;
  logic [NODE_AW-1:0]   scan_idx;
  logic [NODE_W-1:0]    rd_idx;
  logic [NODE_DEPTH-1:0] used;
  logic [NODE_DEPTH-1:0] used_next;
  logic                 any_used;
  logic [NODE_W-1:0]    top_used;
  logic [NODE_W-1:0]    top_used_next;

  // output register
  logic [NODE_W-1:0]    out_index;
  logic                 out_value;
  logic [1:0]           out_status;
  logic                 out_last;

  // control from the output decode
  logic                 out_space;
  logic                 out_load;
  logic [NODE_W-1:0]    load_index;
  logic                 load_value;
  logic [1:0]           load_status;
  logic                 load_last;
  logic                 add_ok;
  logic                 gate_rd;
  logic                 gate_idx_clr;
  logic                 gate_idx_inc;
  logic                 scan_clr;
  logic                 scan_inc;
  logic                 rd_idx_ld;
  node_port_t           node_port;

  // datapath signals
  gate_entry_t          new_gate;
  gate_entry_t          cur_gate;
  logic                 val_a;
  logic                 val_b;
  logic                 alu_y;
  logic                 is_not;
  logic                 a_ok;
  logic                 b_ok;
  logic                 d_ok;
  logic [NODE_AW-1:0]   used_idx;
  logic                 used_hit;
  logic                 read_ok;
  logic                 scan_last;

  assign s_tready  = (state == S_IDLE) && (!m_tvalid || m_tready);
  assign s_accept  = s_tvalid && s_tready;
  assign out_space = !m_tvalid || m_tready;

  assign is_not = (cmd_kind == GT_NOT);
  assign a_ok   = ({1'b0, cmd_a} < (NODE_W + 1)'(NODE_DEPTH));
  assign b_ok   = ({1'b0, cmd_b} < (NODE_W + 1)'(NODE_DEPTH));
  assign d_ok   = ({1'b0, cmd_d} < (NODE_W + 1)'(NODE_DEPTH));

  // one used-flag lookup: scan index while walking, command node otherwise
  assign used_idx  = (state == S_SCAN) ? scan_idx : cmd_a[NODE_AW-1:0];
  assign used_hit  = used[used_idx];
  assign read_ok   = a_ok && used_hit;
  assign scan_last = (NODE_W'(scan_idx) == top_used);

  // gate as stored: a NOT gate takes node_a twice
  assign new_gate.kind = cmd_kind;
  assign new_gate.a    = cmd_a;
  assign new_gate.b    = is_not ? cmd_a : cmd_b;
  assign new_gate.d    = cmd_d;

  nge_gate_mem #(
    .DEPTH (MAX_GATES),
    .AW    (GATE_AW)
  ) u_gate_mem (
    .clk     (clk),
    .wr_en   (add_ok),
    .wr_addr (gate_count[GATE_AW-1:0]),
    .wr_data (new_gate),
    .rd_en   (gate_rd),
    .rd_addr (gate_idx[GATE_AW-1:0]),
    .rd_data (cur_gate)
  );

  nge_node_mem #(
    .DEPTH (NODE_DEPTH),
    .AW    (NODE_AW)
  ) u_node_mem (
    .clk       (clk),
    .rst       (rst),
    .port      (node_port),
    .rd_data_a (val_a),
    .rd_data_b (val_b)
  );

  nge_gate_alu u_gate_alu (
    .kind (cur_gate.kind),
    .a    (val_a),
    .b    (val_b),
    .y    (alu_y)
  );

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (s_accept) begin
          case (cmd_op)
            OP_SIM:  state_next = S_SIM_GATE;
            OP_READ: state_next = read_ok ? S_READ : S_IDLE;
            OP_ALL:  state_next = any_used ? S_SCAN : S_IDLE;
            default: state_next = S_IDLE;
          endcase
        end
      end
      S_READ:      if (out_space) state_next = S_IDLE;
      S_SIM_GATE:  state_next = (gate_idx == gate_count) ? S_SIM_DONE : S_SIM_FETCH;
      S_SIM_FETCH: state_next = S_SIM_EVAL;
      S_SIM_EVAL:  state_next = S_SIM_GATE;
      S_SIM_DONE:  if (out_space) state_next = S_IDLE;
      S_SCAN:      if (used_hit) state_next = S_SCAN_OUT;
      S_SCAN_OUT: begin
        if (out_space) begin
          state_next = scan_last ? S_IDLE : S_SCAN;
        end
      end
      default:     state_next = S_IDLE;
    endcase
  end

  // control and result decode
  always_comb begin
    out_load          = 1'b0;
    load_index        = '0;
    load_value        = 1'b0;
    load_status       = STS_OK;
    load_last         = 1'b1;
    add_ok            = 1'b0;
    gate_rd           = 1'b0;
    gate_idx_clr      = 1'b0;
    gate_idx_inc      = 1'b0;
    scan_clr          = 1'b0;
    scan_inc          = 1'b0;
    rd_idx_ld         = 1'b0;
    node_port         = '0;
    case (state)
      S_IDLE: begin
        if (s_accept) begin
          case (cmd_op)
            OP_ADD: begin
              out_load = 1'b1;
              if (cmd_kind > GT_NOT) begin
                load_status = STS_BAD;
              end else if (gate_count == CNT_W'(MAX_GATES)) begin
                load_status = STS_FULL;
              end else if (!(a_ok && d_ok && (is_not || b_ok))) begin
                load_status = STS_UNUSED;
              end else begin
                add_ok = 1'b1;
              end
            end
            OP_SET: begin
              out_load = 1'b1;
              if (read_ok) begin
                node_port.wr_en   = 1'b1;
                node_port.wr_addr = cmd_a;
                node_port.wr_data = cmd_sv;
              end else begin
                load_status = STS_UNUSED;
              end
            end
            OP_SIM: begin
              gate_idx_clr = 1'b1;
            end
            OP_READ: begin
              rd_idx_ld = 1'b1;
              if (read_ok) begin
                node_port.rd_en = 1'b1;
                node_port.rd_a  = cmd_a;
                node_port.rd_b  = cmd_a;
              end else begin
                out_load    = 1'b1;
                load_index  = cmd_a;
                load_status = STS_UNUSED;
              end
            end
            OP_ALL: begin
              scan_clr = 1'b1;
              if (!any_used) begin
                out_load    = 1'b1;
                load_status = STS_UNUSED;
              end
            end
            default: begin
              out_load    = 1'b1;
              load_status = STS_BAD;
            end
          endcase
        end
      end
      S_READ: begin
        if (out_space) begin
          out_load   = 1'b1;
          load_index = rd_idx;
          load_value = val_a;
        end
      end
      S_SIM_GATE: begin
        gate_rd = (gate_idx != gate_count);
      end
      S_SIM_FETCH: begin
        node_port.rd_en = 1'b1;
        node_port.rd_a  = cur_gate.a;
        node_port.rd_b  = cur_gate.b;
      end
      S_SIM_EVAL: begin
        node_port.wr_en   = 1'b1;
        node_port.wr_addr = cur_gate.d;
        node_port.wr_data = alu_y;
        gate_idx_inc      = 1'b1;
      end
      S_SIM_DONE: begin
        out_load = out_space;
      end
      S_SCAN: begin
        if (used_hit) begin
          node_port.rd_en = 1'b1;
          node_port.rd_a  = NODE_W'(scan_idx);
          node_port.rd_b  = NODE_W'(scan_idx);
        end else begin
          scan_inc = 1'b1;
        end
      end
      S_SCAN_OUT: begin
        if (out_space) begin
          out_load   = 1'b1;
          load_index = NODE_W'(scan_idx);
          load_value = val_a;
          load_last  = scan_last;
          scan_inc   = !scan_last;
        end
      end
      default: begin
      end
    endcase
  end

  // highest used node after an add
  always_comb begin
    top_used_next = any_used ? top_used : '0;
    if (cmd_a > top_used_next) top_used_next = cmd_a;
    if (new_gate.b > top_used_next) top_used_next = new_gate.b;
    if (cmd_d > top_used_next) top_used_next = cmd_d;
  end

  // used flags after an add
  always_comb begin
    used_next                          = used;
    used_next[cmd_a[NODE_AW-1:0]]      = 1'b1;
    used_next[new_gate.b[NODE_AW-1:0]] = 1'b1;
    used_next[cmd_d[NODE_AW-1:0]]      = 1'b1;
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      gate_count <= '0;
      used       <= '0;
      any_used   <= 1'b0;
      top_used   <= '0;
      gate_idx   <= '0;
      scan_idx   <= '0;
      m_tvalid   <= 1'b0;
    end else begin
      state <= state_next;
      if (add_ok) begin
        gate_count <= gate_count + 1'b1;
        used       <= used_next;
        any_used   <= 1'b1;
        top_used   <= top_used_next;
      end
      if (gate_idx_clr) begin
        gate_idx <= '0;
      end else if (gate_idx_inc) begin
        gate_idx <= gate_idx + 1'b1;
      end
      if (scan_clr) begin
        scan_idx <= '0;
      end else if (scan_inc) begin
        scan_idx <= scan_idx + 1'b1;
      end
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (rd_idx_ld) begin
      rd_idx <= cmd_a;
    end
    if (out_load) begin
      out_index  <= load_index;
      out_value  <= load_value;
      out_status <= load_status;
      out_last   <= load_last;
    end
  end

  assign m_tdata = {1'b0, out_value, out_index};
  assign m_tuser = out_status;
  assign m_tlast = out_last;

  // checks
  a_gate_count_bound: assert property (@(posedge clk) disable iff (rst)
    gate_count <= CNT_W'(MAX_GATES))
    else $error("gate count beyond table size");

  a_gate_idx_bound: assert property (@(posedge clk) disable iff (rst)
    gate_idx <= gate_count)
    else $error("simulation index past gate count");

  a_busy_not_ready: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> !s_tready)
    else $error("command accepted while sequencer busy");

  a_sim_starts: assert property (@(posedge clk) disable iff (rst)
    (s_accept && cmd_op == OP_SIM) |=> (state == S_SIM_GATE))
    else $error("simulate command did not start the gate walk");

  a_eval_writes_used: assert property (@(posedge clk) disable iff (rst)
    (node_port.wr_en) |-> used[node_port.wr_addr[NODE_AW-1:0]])
    else $error("node value written to an unused node");

endmodule

`default_nettype wire
